// ----- hw/rtl/agre_pkg.sv -----
// Shared types and constants for the adaptive-gain RTT estimator.
// Holds field widths, register indexes, the controller state type and the
// command/status structs. Depends on nothing.
package agre_pkg;

    localparam int TIME_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W  = 24;
    localparam int OUT_W     = 24;
    localparam int RATIO_W   = 17;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] ALPHA_BASE_RST = 16'd8192;
    localparam logic [CFG_W-1:0] BETA_BASE_RST  = 16'd16384;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_BASE = 1'b0,
        CFG_BETA_BASE  = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_ALPHA,
        S_BETA,
        S_SMUL,
        S_SUPD,
        S_ERR,
        S_VLOAD,
        S_VMUL,
        S_VUPD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic op_clear;
        logic op_first;
        logic div_start;
        logic div_step;
        logic calc_alpha;
        logic calc_beta;
        logic mul_load_srtt;
        logic mul_load_var;
        logic mul_step;
        logic srtt_update;
        logic err_calc;
        logic var_update;
        logic commit_sample;
        logic write_out;
    } agre_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic have_sample;
    } agre_status_t;

endpackage

// ----- hw/rtl/agre_if.sv -----
// Valid/ready channel interfaces for the estimator's sample and estimate words.
// Depends on agre_pkg for the payload widths.
interface agre_sample_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [agre_pkg::SAMPLE_W-1:0]  rtt_sample;

    modport source (output valid, cmd, rtt_sample, input ready);
    modport sink   (input valid, cmd, rtt_sample, output ready);
endinterface

interface agre_estimate_if;
    logic                           valid;
    logic                           ready;
    logic [agre_pkg::OUT_W-1:0]     smoothed_rtt;
    logic [agre_pkg::OUT_W-1:0]     rtt_variation;
    logic [agre_pkg::RATIO_W-1:0]   change_ratio;

    modport source (output valid, smoothed_rtt, rtt_variation, change_ratio, input ready);
    modport sink   (input valid, smoothed_rtt, rtt_variation, change_ratio, output ready);
endinterface

// ----- hw/rtl/agre_ctrl.sv -----
// Sequencing state machine of the estimator: steps the datapath through
// divide, gain, multiply and update phases and owns the output valid flag.
// Depends on agre_pkg.
module agre_ctrl #(
    parameter int FRAC_BITS = agre_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  agre_pkg::agre_status_t status,
    output agre_pkg::agre_cmd_t    cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    agre_pkg::state_t   state_reg;
    agre_pkg::state_t   state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= agre_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            agre_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = agre_pkg::S_PREP;
                end
            end
            agre_pkg::S_PREP:
            begin
                if (status.is_clear)
                begin
                    cmd.op_clear = 1'b1;
                    state_next   = agre_pkg::S_OUT;
                end
                else if (!status.have_sample)
                begin
                    cmd.op_first = 1'b1;
                    state_next   = agre_pkg::S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = agre_pkg::S_DIV;
                end
            end
            agre_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = agre_pkg::S_ALPHA;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            agre_pkg::S_ALPHA:
            begin
                cmd.calc_alpha = 1'b1;
                state_next     = agre_pkg::S_BETA;
            end
            agre_pkg::S_BETA:
            begin
                cmd.calc_beta     = 1'b1;
                cmd.mul_load_srtt = 1'b1;
                state_next        = agre_pkg::S_SMUL;
            end
            agre_pkg::S_SMUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    cnt_next   = '0;
                    state_next = agre_pkg::S_SUPD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            agre_pkg::S_SUPD:
            begin
                cmd.srtt_update = 1'b1;
                state_next      = agre_pkg::S_ERR;
            end
            agre_pkg::S_ERR:
            begin
                cmd.err_calc = 1'b1;
                state_next   = agre_pkg::S_VLOAD;
            end
            agre_pkg::S_VLOAD:
            begin
                cmd.mul_load_var = 1'b1;
                state_next       = agre_pkg::S_VMUL;
            end
            agre_pkg::S_VMUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    cnt_next   = '0;
                    state_next = agre_pkg::S_VUPD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            agre_pkg::S_VUPD:
            begin
                cmd.var_update = 1'b1;
                state_next     = agre_pkg::S_OUT;
            end
            agre_pkg::S_OUT:
            begin
                // The result register is free once its word has been taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write_out     = 1'b1;
                    cmd.commit_sample = !status.is_clear;
                    state_next        = agre_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = agre_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.write_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_out |-> (!out_valid_reg || out_ready))
        else $error("result register written while its word is still pending");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == agre_pkg::S_PREP))
        else $error("accepted word did not start a step");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == agre_pkg::S_DIV) |-> (cnt_reg < CNT_W'(FRAC_BITS)))
        else $error("divider step count out of range");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == agre_pkg::S_OUT))
        else $error("result valid raised outside the output state");

endmodule

// ----- hw/rtl/agre_dp.sv -----
// Datapath of the estimator: configuration registers, estimator state,
// restoring divider for the change ratio, gain multiplier, shift-add blend
// multiplier and the result register. Depends on agre_pkg.
module agre_dp #(
    parameter int TIME_BITS = agre_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = agre_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [agre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [agre_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_cmd,
    input  logic [agre_pkg::SAMPLE_W-1:0]   in_sample,
    input  agre_pkg::agre_cmd_t             cmd,
    output agre_pkg::agre_status_t          status,
    output logic [agre_pkg::OUT_W-1:0]      smoothed_rtt,
    output logic [agre_pkg::OUT_W-1:0]      rtt_variation,
    output logic [agre_pkg::RATIO_W-1:0]    change_ratio
);

    localparam int T      = TIME_BITS;
    localparam int F      = FRAC_BITS;
    localparam int ACC_W  = T + F;
    localparam int WIDE_W = (T > agre_pkg::OUT_W) ? T : agre_pkg::OUT_W;
    localparam int Q_SHL  = (F >= 16) ? F - 16 : 0;
    localparam int Q_SHR  = (F < 16) ? 16 - F : 0;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [F:0]       ONE_K   = {1'b1, {F{1'b0}}};

    logic [agre_pkg::CFG_W-1:0] alpha_base_reg;
    logic [agre_pkg::CFG_W-1:0] beta_base_reg;
    logic                       clear_reg;
    logic [ACC_W-1:0]           srtt_reg;
    logic [ACC_W-1:0]           var_reg;
    logic [T-1:0]               last_reg;
    logic                       have_reg;

    logic [T-1:0]               t_reg;
    logic [T-1:0]               rem_reg;
    logic [F-1:0]               quot_reg;
    logic                       sat_reg;
    logic                       zero_reg;
    logic [F:0]                 k_reg;
    logic [F:0]                 alpha_reg;
    logic [F:0]                 beta_reg;
    logic [ACC_W-1:0]           err_reg;
    logic [ACC_W-1:0]           mcand_reg;
    logic [F:0]                 mplier_reg;
    logic [ACC_W-1:0]           prod_hi_reg;
    logic                       down_reg;
    logic [agre_pkg::OUT_W-1:0]   srtt_out_reg;
    logic [agre_pkg::OUT_W-1:0]   var_out_reg;
    logic [agre_pkg::RATIO_W-1:0] ratio_out_reg;

    logic [ACC_W-1:0]   t_acc;
    logic [T-1:0]       diff;
    logic [T:0]         rem2;
    logic               rem_ge;
    logic [F:0]         k_eff;
    logic [F-1:0]       alpha_f;
    logic [F-1:0]       beta_f;
    logic [F-1:0]       gm_a;
    logic [F+1:0]       gm_b;
    logic [2*F+1:0]     gm_prod;
    logic [F:0]         gain;
    logic [ACC_W-1:0]   bl_tgt;
    logic [ACC_W-1:0]   bl_old;
    logic               bl_down;
    logic [ACC_W-1:0]   bl_mag;
    logic [ACC_W:0]     mul_sum;
    logic [ACC_W:0]     step_q;
    logic [ACC_W-1:0]   step_amt;
    logic [ACC_W-1:0]   upd_old;
    logic [ACC_W:0]     upd_sum;
    logic [ACC_W-1:0]   upd_new;
    logic [ACC_W-1:0]   err_val;

    function automatic logic [agre_pkg::OUT_W-1:0] out_int(input logic [ACC_W-1:0] acc);
        logic [WIDE_W-1:0] ip;
        ip = WIDE_W'(acc[ACC_W-1:F]);
        if (ip > WIDE_W'({agre_pkg::OUT_W{1'b1}}))
        begin
            return '1;
        end
        return agre_pkg::OUT_W'(ip);
    endfunction

    function automatic logic [agre_pkg::RATIO_W-1:0] ratio_q16(input logic [F:0] k);
        logic [39:0] kx;
        kx = 40'(k);
        if (F >= 16)
        begin
            kx = kx >> (F - 16);
        end
        else
        begin
            kx = kx << (16 - F);
        end
        return agre_pkg::RATIO_W'(kx);
    endfunction

    assign t_acc   = {t_reg, {F{1'b0}}};
    assign diff    = (t_reg >= last_reg) ? t_reg - last_reg : last_reg - t_reg;
    assign rem2    = {rem_reg, 1'b0};
    assign rem_ge  = rem2 >= {1'b0, last_reg};
    assign k_eff   = zero_reg ? '0 : (sat_reg ? ONE_K : {1'b0, quot_reg});

    // Register gains are Q0.16; rescale them to the internal fraction width.
    assign alpha_f = F'((32'(alpha_base_reg) << Q_SHL) >> Q_SHR);
    assign beta_f  = F'((32'(beta_base_reg) << Q_SHL) >> Q_SHR);

    // One multiplier serves both gains, in consecutive cycles.
    assign gm_a    = cmd.calc_alpha ? alpha_f : beta_f;
    assign gm_b    = cmd.calc_alpha ? (F+2)'(ONE_K) + (F+2)'(k_eff)
                                    : (F+2)'(ONE_K) - (F+2)'(k_reg);
    assign gm_prod = (2*F+2)'(gm_a) * (2*F+2)'(gm_b);
    assign gain    = gm_prod[2*F:F];

    assign bl_tgt  = cmd.mul_load_var ? err_reg : t_acc;
    assign bl_old  = cmd.mul_load_var ? var_reg : srtt_reg;
    assign bl_down = bl_tgt < bl_old;
    assign bl_mag  = bl_down ? bl_old - bl_tgt : bl_tgt - bl_old;

    // Shift-add multiply, one multiplier bit per cycle, least significant first.
    assign mul_sum = {1'b0, prod_hi_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);

    // Product bits above the fraction point, saturated to the accumulator range.
    assign step_q   = {prod_hi_reg, mplier_reg[F]};
    assign step_amt = step_q[ACC_W] ? ACC_MAX : step_q[ACC_W-1:0];

    assign upd_old = cmd.var_update ? var_reg : srtt_reg;
    assign upd_sum = {1'b0, upd_old} + {1'b0, step_amt};

    always_comb
    begin
        if (!down_reg)
        begin
            upd_new = upd_sum[ACC_W] ? ACC_MAX : upd_sum[ACC_W-1:0];
        end
        else if (step_amt > upd_old)
        begin
            upd_new = '0;
        end
        else
        begin
            upd_new = upd_old - step_amt;
        end
    end

    assign err_val = (t_acc >= srtt_reg) ? t_acc - srtt_reg : srtt_reg - t_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_base_reg <= agre_pkg::ALPHA_BASE_RST;
            beta_base_reg  <= agre_pkg::BETA_BASE_RST;
            clear_reg      <= 1'b0;
            srtt_reg       <= '0;
            var_reg        <= '0;
            last_reg       <= '0;
            have_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (agre_pkg::cfg_index_t'(cfg_index))
                    agre_pkg::CFG_ALPHA_BASE: alpha_base_reg <= cfg_data;
                    agre_pkg::CFG_BETA_BASE:  beta_base_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.load_in)
            begin
                clear_reg <= (in_cmd == agre_pkg::CMD_CLEAR);
            end

            if (cmd.op_clear)
            begin
                srtt_reg <= '0;
                var_reg  <= '0;
                last_reg <= '0;
                have_reg <= 1'b0;
            end
            else if (cmd.op_first)
            begin
                srtt_reg <= t_acc;
                var_reg  <= t_acc >> 1;
            end
            else if (cmd.srtt_update)
            begin
                srtt_reg <= upd_new;
            end
            else if (cmd.var_update)
            begin
                var_reg <= upd_new;
            end

            if (cmd.commit_sample)
            begin
                last_reg <= t_reg;
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            t_reg <= T'(in_sample);
        end

        if (cmd.div_start)
        begin
            rem_reg  <= diff;
            quot_reg <= '0;
            sat_reg  <= diff >= last_reg;
            zero_reg <= last_reg == '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? T'(rem2 - {1'b0, last_reg}) : rem2[T-1:0];
            quot_reg <= {quot_reg[F-2:0], rem_ge};
        end

        if (cmd.op_clear || cmd.op_first)
        begin
            k_reg <= '0;
        end
        else if (cmd.calc_alpha)
        begin
            k_reg <= k_eff;
        end

        if (cmd.calc_alpha)
        begin
            alpha_reg <= gain;
        end
        if (cmd.calc_beta)
        begin
            beta_reg <= gain;
        end

        if (cmd.err_calc)
        begin
            err_reg <= err_val;
        end

        if (cmd.mul_load_srtt || cmd.mul_load_var)
        begin
            mcand_reg   <= bl_mag;
            mplier_reg  <= cmd.mul_load_var ? beta_reg : alpha_reg;
            prod_hi_reg <= '0;
            down_reg    <= bl_down;
        end
        else if (cmd.mul_step)
        begin
            prod_hi_reg <= mul_sum[ACC_W:1];
            mplier_reg  <= {mul_sum[0], mplier_reg[F:1]};
        end

        if (cmd.write_out)
        begin
            srtt_out_reg  <= out_int(srtt_reg);
            var_out_reg   <= out_int(var_reg);
            ratio_out_reg <= ratio_q16(k_reg);
        end
    end

    assign status.is_clear    = clear_reg;
    assign status.have_sample = have_reg;

    assign smoothed_rtt  = srtt_out_reg;
    assign rtt_variation = var_out_reg;
    assign change_ratio  = ratio_out_reg;

endmodule

// ----- hw/rtl/adaptive_gain_rtt_estimator_unit.sv -----
// Adaptive-gain RTT estimator. A sample word passes through the FRAC_BITS-step
// restoring divider for the change ratio and two FRAC_BITS+1 step passes of the
// shared shift-add multiplier; a clear word, and the first sample after reset or
// a clear, skip these and go straight to the output state. One word is in work at
// a time; the next word is taken the cycle after the result register is loaded.
// A result still waiting in the output register holds the step in its last state
// until that word is taken.
// Depends on agre_pkg, agre_if, agre_ctrl and agre_dp.
module adaptive_gain_rtt_estimator_unit #(
    parameter int TIME_BITS = agre_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = agre_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    agre_sample_if.sink                     samples,
    agre_estimate_if.source                 estimates,
    input  logic                            cfg_we,
    input  logic [agre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [agre_pkg::CFG_W-1:0]      cfg_data
);

    agre_pkg::agre_cmd_t    cmd;
    agre_pkg::agre_status_t status;
    logic                   in_ready;
    logic                   out_valid;

    agre_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (estimates.ready),
        .status    (status),
        .cmd       (cmd)
    );

    agre_dp #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_cmd        (samples.cmd),
        .in_sample     (samples.rtt_sample),
        .cmd           (cmd),
        .status        (status),
        .smoothed_rtt  (estimates.smoothed_rtt),
        .rtt_variation (estimates.rtt_variation),
        .change_ratio  (estimates.change_ratio)
    );

    assign samples.ready   = in_ready;
    assign estimates.valid = out_valid;

endmodule

// ----- dv/adaptive_gain_rtt_estimator_unit_test.sv -----
// Self-checking testbench for adaptive_gain_rtt_estimator_unit: drives sample and clear
// words, predicts every estimate word and compares it field by field.
// Depends on agre_pkg, agre_if and the estimator RTL.
module adaptive_gain_rtt_estimator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ACC_LIMIT = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] ONE_Q16   = 64'h1_0000;
    localparam logic [23:0] RTT_MAX   = 24'hFF_FFFF;
    localparam int          PHASES    = 8;
    localparam int          PHASE_WORDS = 140;

    typedef struct packed {
        logic [agre_pkg::OUT_W-1:0]   srtt;
        logic [agre_pkg::OUT_W-1:0]   rttvar;
        logic [agre_pkg::RATIO_W-1:0] ratio;
    } estimate_t;

    class estimate_tracker;
        estimate_t                  pending[$];
        int unsigned                errors;
        logic [agre_pkg::CFG_W-1:0] alpha_gain;
        logic [agre_pkg::CFG_W-1:0] beta_gain;
        logic [63:0]                srtt_q;
        logic [63:0]                var_q;
        logic [63:0]                prev_rtt;
        bit                         seen_rtt;

        function new();
            alpha_gain = agre_pkg::ALPHA_BASE_RST;
            beta_gain  = agre_pkg::BETA_BASE_RST;
            srtt_q     = '0;
            var_q      = '0;
            prev_rtt   = '0;
            seen_rtt   = 1'b0;
            errors     = 0;
        endfunction

        function void set_gain(agre_pkg::cfg_index_t idx, logic [agre_pkg::CFG_W-1:0] val);
            if (idx == agre_pkg::CFG_ALPHA_BASE)
                alpha_gain = val;
            else
                beta_gain = val;
        endfunction

        // floor(gain * v) with the gain in Q1.16, saturated to the accumulator.
        function logic [63:0] gain_product(logic [63:0] gain, logic [63:0] v);
            logic [63:0] p;
            p = (gain * v) >> 16;
            return (p > ACC_LIMIT) ? ACC_LIMIT : p;
        endfunction

        function logic [63:0] move_toward(logic [63:0] old, logic [63:0] target,
                                          logic [63:0] gain);
            logic [63:0] step;
            if (target >= old)
            begin
                step = gain_product(gain, target - old);
                return (step > ACC_LIMIT - old) ? ACC_LIMIT : old + step;
            end
            step = gain_product(gain, old - target);
            return (step > old) ? 64'd0 : old - step;
        endfunction

        function logic [agre_pkg::OUT_W-1:0] integer_part(logic [63:0] acc);
            logic [63:0] v;
            v = acc >> 16;
            return (v > 64'(RTT_MAX)) ? RTT_MAX : v[agre_pkg::OUT_W-1:0];
        endfunction

        function void note_sample(logic cmd, logic [agre_pkg::SAMPLE_W-1:0] rtt);
            estimate_t   e;
            logic [63:0] t_acc;
            logic [63:0] ratio;
            logic [63:0] diff;
            logic [63:0] alpha;
            logic [63:0] beta;
            logic [63:0] err;
            ratio = '0;
            t_acc = 64'(rtt) << 16;
            if (cmd == agre_pkg::CMD_CLEAR)
            begin
                srtt_q   = '0;
                var_q    = '0;
                prev_rtt = '0;
                seen_rtt = 1'b0;
                e        = '0;
                pending.push_back(e);
                return;
            end
            if (!seen_rtt)
            begin
                srtt_q = t_acc;
                var_q  = t_acc >> 1;
            end
            else
            begin
                if (prev_rtt != 0)
                begin
                    diff  = (64'(rtt) >= prev_rtt) ? 64'(rtt) - prev_rtt : prev_rtt - 64'(rtt);
                    ratio = (diff >= prev_rtt) ? ONE_Q16 : (diff << 16) / prev_rtt;
                end
                alpha  = (64'(alpha_gain) * (ONE_Q16 + ratio)) >> 16;
                beta   = (64'(beta_gain) * (ONE_Q16 - ratio)) >> 16;
                srtt_q = move_toward(srtt_q, t_acc, alpha);
                // The variation error is taken against the freshly updated srtt.
                err    = (t_acc >= srtt_q) ? t_acc - srtt_q : srtt_q - t_acc;
                var_q  = move_toward(var_q, err, beta);
            end
            prev_rtt = 64'(rtt);
            seen_rtt = 1'b1;
            e.srtt   = integer_part(srtt_q);
            e.rttvar = integer_part(var_q);
            e.ratio  = ratio[agre_pkg::RATIO_W-1:0];
            pending.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            // Keep the log bounded when something is badly broken.
            if (errors <= 100)
                $display("%0t ns: MISMATCH %s", $time, msg);
        endtask

        task check_estimate(logic [agre_pkg::OUT_W-1:0] srtt,
                            logic [agre_pkg::OUT_W-1:0] rttvar,
                            logic [agre_pkg::RATIO_W-1:0] ratio);
            estimate_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("estimate word with none outstanding: srtt=%0d var=%0d k=%0d",
                                 srtt, rttvar, ratio));
                return;
            end
            want = pending.pop_front();
            if (srtt !== want.srtt)
                report($sformatf("smoothed_rtt got %0d want %0d", srtt, want.srtt));
            if (rttvar !== want.rttvar)
                report($sformatf("rtt_variation got %0d want %0d", rttvar, want.rttvar));
            if (ratio !== want.ratio)
                report($sformatf("change_ratio got %0d want %0d", ratio, want.ratio));
        endtask
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [agre_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [agre_pkg::CFG_W-1:0]         cfg_data;

    agre_sample_if   sample_ch();
    agre_estimate_if estimate_ch();

    adaptive_gain_rtt_estimator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .estimates (estimate_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    estimate_tracker    sb;
    int                 idle_pct;
    int                 stall_pct;
    logic [23:0]        last_rtt;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Estimate side: check each accepted word and pick the next ready value.
    initial
    begin
        estimate_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && estimate_ch.valid && estimate_ch.ready)
                sb.check_estimate(estimate_ch.smoothed_rtt, estimate_ch.rtt_variation,
                                  estimate_ch.change_ratio);
            estimate_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(agre_pkg::cfg_index_t idx, logic [agre_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_gain(idx, val);
    endtask

    task automatic send_word(logic cmd, logic [agre_pkg::SAMPLE_W-1:0] rtt);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.cmd        <= cmd;
        sample_ch.rtt_sample <= rtt;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_sample(cmd, rtt);
        if (cmd == agre_pkg::CMD_SAMPLE)
            last_rtt = rtt;
    endtask

    task automatic drain_estimates();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Often samples related to the previous one, so the change ratio spans
    // its whole range, mixed with extremes and fully random values.
    function automatic logic [23:0] pick_rtt(logic [23:0] prev);
        logic [24:0]    sum;
        logic [23:0]    span;
        logic [23:0]    d;
        int             w;
        case ($urandom_range(9))
            0, 1:    return 24'($urandom);
            2, 3, 4:
            begin
                span = prev >> 2;
                d    = (span == 0) ? 24'd0 : 24'($urandom_range(32'(span)));
                if ($urandom_range(1))
                begin
                    sum = 25'(prev) + 25'(d);
                    return sum[24] ? RTT_MAX : sum[23:0];
                end
                return prev - d;
            end
            5:       return 24'($urandom_range(255));
            6:
            begin
                case ($urandom_range(3))
                    0:       return 24'd0;
                    1:       return 24'd1;
                    2:       return RTT_MAX;
                    default: return RTT_MAX - 24'd1;
                endcase
            end
            7:       return $urandom_range(1) ? (prev[23] ? RTT_MAX : prev << 1) : prev >> 1;
            default:
            begin
                w = $urandom_range(24, 1);
                return 24'($urandom) & 24'((32'd1 << w) - 1);
            end
        endcase
    endfunction

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= agre_pkg::CFG_ALPHA_BASE;
        cfg_data             <= '0;
        sample_ch.valid      <= 1'b0;
        sample_ch.cmd        <= agre_pkg::CMD_SAMPLE;
        sample_ch.rtt_sample <= '0;
        sb        = new();
        idle_pct  = 0;
        stall_pct = 0;
        last_rtt  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the default gains.
        write_reg(agre_pkg::CFG_ALPHA_BASE, agre_pkg::ALPHA_BASE_RST);
        write_reg(agre_pkg::CFG_BETA_BASE, agre_pkg::BETA_BASE_RST);
        send_word(agre_pkg::CMD_CLEAR, 24'd0);
        send_word(agre_pkg::CMD_SAMPLE, 24'd0);
        send_word(agre_pkg::CMD_SAMPLE, 24'd0);          // previous sample zero
        send_word(agre_pkg::CMD_SAMPLE, RTT_MAX);        // previous sample still zero
        send_word(agre_pkg::CMD_SAMPLE, 24'd1);          // ratio just below one
        send_word(agre_pkg::CMD_SAMPLE, 24'd2);          // change equal to previous
        send_word(agre_pkg::CMD_SAMPLE, 24'd3);          // ratio one half
        send_word(agre_pkg::CMD_SAMPLE, 24'd3);          // no change
        send_word(agre_pkg::CMD_SAMPLE, 24'd4);
        send_word(agre_pkg::CMD_CLEAR, RTT_MAX);
        send_word(agre_pkg::CMD_SAMPLE, RTT_MAX);        // first sample, variation is half
        send_word(agre_pkg::CMD_SAMPLE, RTT_MAX);
        send_word(agre_pkg::CMD_SAMPLE, 24'd0);
        send_word(agre_pkg::CMD_SAMPLE, 24'd100);
        send_word(agre_pkg::CMD_CLEAR, 24'd0);
        sample_ch.valid <= 1'b0;
        drain_estimates();

        // Largest gains: srtt overshoots and clamps at both ends.
        write_reg(agre_pkg::CFG_ALPHA_BASE, 16'hFFFF);
        write_reg(agre_pkg::CFG_BETA_BASE, 16'hFFFF);
        send_word(agre_pkg::CMD_SAMPLE, 24'd1);
        send_word(agre_pkg::CMD_SAMPLE, RTT_MAX);
        send_word(agre_pkg::CMD_SAMPLE, RTT_MAX);
        send_word(agre_pkg::CMD_SAMPLE, 24'd0);
        send_word(agre_pkg::CMD_SAMPLE, 24'd200);
        send_word(agre_pkg::CMD_SAMPLE, 24'd10);
        send_word(agre_pkg::CMD_CLEAR, 24'd5);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            sample_ch.valid <= 1'b0;
            drain_estimates();
            case (ph)
                0:
                begin
                    write_reg(agre_pkg::CFG_ALPHA_BASE, agre_pkg::ALPHA_BASE_RST);
                    write_reg(agre_pkg::CFG_BETA_BASE, agre_pkg::BETA_BASE_RST);
                end
                1:
                begin
                    write_reg(agre_pkg::CFG_ALPHA_BASE, 16'h0000);
                    write_reg(agre_pkg::CFG_BETA_BASE, 16'h0000);
                end
                2:
                begin
                    write_reg(agre_pkg::CFG_ALPHA_BASE, 16'hFFFF);
                    write_reg(agre_pkg::CFG_BETA_BASE, 16'hFFFF);
                end
                3:
                begin
                    write_reg(agre_pkg::CFG_ALPHA_BASE, 16'h0000);
                    write_reg(agre_pkg::CFG_BETA_BASE, 16'hFFFF);
                end
                4:
                begin
                    write_reg(agre_pkg::CFG_ALPHA_BASE, 16'hFFFF);
                    write_reg(agre_pkg::CFG_BETA_BASE, 16'h0000);
                end
                default:
                begin
                    write_reg(agre_pkg::CFG_ALPHA_BASE, 16'($urandom));
                    write_reg(agre_pkg::CFG_BETA_BASE, 16'($urandom));
                end
            endcase
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 79;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 79;
                end
                default:
                begin
                    idle_pct  = 35;
                    stall_pct = 35;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(99) < 4)
                    send_word(agre_pkg::CMD_CLEAR, 24'($urandom));
                else
                    send_word(agre_pkg::CMD_SAMPLE, pick_rtt(last_rtt));
            end
        end

        sample_ch.valid <= 1'b0;
        drain_estimates();
        // Give a stray extra word time to show up.
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- adaptive_gain_rtt_estimator_unit.f -----
hw/rtl/agre_pkg.sv
hw/rtl/agre_if.sv
hw/rtl/agre_ctrl.sv
hw/rtl/agre_dp.sv
hw/rtl/adaptive_gain_rtt_estimator_unit.sv
dv/adaptive_gain_rtt_estimator_unit_test.sv
